### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// check that a condition is followed in the next cycle by a consequence
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/v3g_pkg.sv
package v3g_pkg;

    localparam int V3G_FRAC_BITS = 16;
    localparam int IN_W          = 24;
    localparam int OUT_W         = 40;
    localparam int OP_W          = 3;

    localparam logic [OP_W-1:0] OP_DOT     = 3'd0;
    localparam logic [OP_W-1:0] OP_NORM    = 3'd1;
    localparam logic [OP_W-1:0] OP_DIST    = 3'd2;
    localparam logic [OP_W-1:0] OP_ANGLE   = 3'd3;
    localparam logic [OP_W-1:0] OP_ANGLE_X = 3'd4;

    localparam int RAD_W        = 64;
    localparam int SQRT_W       = 32;
    localparam int COS_FRAC     = 30;
    localparam int Q_W          = COS_FRAC + 1;
    localparam int DIV_STEPS    = COS_FRAC;
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_W     = 36;

    localparam logic [Q_W-1:0]             Q_ONE  = Q_W'(1) << COS_FRAC;
    localparam logic signed [CORDIC_W-1:0] PI_Q30 = 36'sd3373259426;

    typedef struct packed {
        logic en;
        logic valid;
    } stage_ctl_t;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [OUT_W-1:0] dot_res;
        logic                    pos;
        logic [SQRT_W-1:0]       norm;
        logic                    dneg;
    } side_t;

    function automatic logic signed [CORDIC_W-1:0] atan_q30(input int idx);
        logic signed [CORDIC_W-1:0] val;
        case (idx)
            0:  val = 36'sd843314856;
            1:  val = 36'sd497837829;
            2:  val = 36'sd263043836;
            3:  val = 36'sd133525158;
            4:  val = 36'sd67021686;
            5:  val = 36'sd33543515;
            6:  val = 36'sd16775850;
            7:  val = 36'sd8388437;
            8:  val = 36'sd4194282;
            9:  val = 36'sd2097149;
            10: val = 36'sd1048575;
            11: val = 36'sd524287;
            12: val = 36'sd262143;
            13: val = 36'sd131071;
            14: val = 36'sd65535;
            15: val = 36'sd32767;
            16: val = 36'sd16383;
            17: val = 36'sd8191;
            18: val = 36'sd4095;
            19: val = 36'sd2047;
            20: val = 36'sd1023;
            21: val = 36'sd511;
            22: val = 36'sd255;
            23: val = 36'sd127;
            24: val = 36'sd63;
            25: val = 36'sd31;
            26: val = 36'sd15;
            27: val = 36'sd7;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

### design/v3g_sqrt.sv
module v3g_sqrt
    import v3g_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  stage_ctl_t          ctl,
    input  logic [RAD_W-1:0]    radicand,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    output logic [SQRT_W-1:0]   root,
    output logic [SIDE_W-1:0]   side_out
);

    localparam int STEPS = RAD_W / 2;

    logic [RAD_W-1:0]  rem_reg  [STEPS];
    logic [RAD_W-1:0]  res_reg  [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic [RAD_W-1:0]  rem_src  [STEPS];
    logic [RAD_W-1:0]  res_src  [STEPS];
    logic [SIDE_W-1:0] side_src [STEPS];
    logic [RAD_W-1:0]  trial    [STEPS];
    logic [RAD_W-1:0]  rem_next [STEPS];
    logic [RAD_W-1:0]  res_next [STEPS];
    logic [STEPS-1:0]  valid_reg;
    logic              out_valid_reg;
    logic [SQRT_W-1:0] root_reg;
    logic [SIDE_W-1:0] side_out_reg;

    // one result bit per stage
    always_comb
    begin
        rem_src[0]  = radicand;
        res_src[0]  = '0;
        side_src[0] = side_in;
        for (int k = 1; k < STEPS; k++)
        begin
            rem_src[k]  = rem_reg[k-1];
            res_src[k]  = res_reg[k-1];
            side_src[k] = side_reg[k-1];
        end
        for (int k = 0; k < STEPS; k++)
        begin
            trial[k] = res_src[k] + (RAD_W'(1) << (RAD_W - 2 - 2 * k));
            if (rem_src[k] >= trial[k])
            begin
                rem_next[k] = rem_src[k] - trial[k];
                res_next[k] = (res_src[k] >> 1) + (RAD_W'(1) << (RAD_W - 2 - 2 * k));
            end
            else
            begin
                rem_next[k] = rem_src[k];
                res_next[k] = res_src[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            valid_reg     <= {valid_reg[STEPS-2:0], ctl.valid};
            out_valid_reg <= valid_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                res_reg[k]  <= res_next[k];
                side_reg[k] <= side_src[k];
            end
            // round to nearest
            if (rem_reg[STEPS-1] > res_reg[STEPS-1])
            begin
                root_reg <= res_reg[STEPS-1][SQRT_W-1:0] + SQRT_W'(1);
            end
            else
            begin
                root_reg <= res_reg[STEPS-1][SQRT_W-1:0];
            end
            side_out_reg <= side_reg[STEPS-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign root      = root_reg;
    assign side_out  = side_out_reg;

endmodule

### design/v3g_div.sv
`include "assert_macros.svh"

module v3g_div
    import v3g_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  stage_ctl_t          ctl,
    input  logic [RAD_W-1:0]    dividend,
    input  logic [RAD_W-1:0]    divisor,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    output logic [Q_W-1:0]      quotient,
    output logic [SIDE_W-1:0]   side_out
);

    logic                 pre_valid_reg;
    logic [RAD_W-1:0]     r_pre_reg;
    logic [RAD_W-1:0]     p_pre_reg;
    logic                 big_pre_reg;
    logic [SIDE_W-1:0]    side_pre_reg;

    logic [DIV_STEPS-1:0] valid_reg;
    logic [RAD_W-1:0]     r_reg    [DIV_STEPS];
    logic [RAD_W-1:0]     p_reg    [DIV_STEPS];
    logic [Q_W-1:0]       q_reg    [DIV_STEPS];
    logic                 big_reg  [DIV_STEPS];
    logic [SIDE_W-1:0]    side_reg [DIV_STEPS];

    logic [RAD_W-1:0]     r_src    [DIV_STEPS];
    logic [RAD_W-1:0]     p_src    [DIV_STEPS];
    logic [Q_W-1:0]       q_src    [DIV_STEPS];
    logic                 big_src  [DIV_STEPS];
    logic [SIDE_W-1:0]    side_src [DIV_STEPS];
    logic [RAD_W-1:0]     r_sh     [DIV_STEPS];
    logic [RAD_W-1:0]     r_next   [DIV_STEPS];
    logic [Q_W-1:0]       q_next   [DIV_STEPS];

    // restoring division, one quotient bit per stage
    always_comb
    begin
        r_src[0]    = r_pre_reg;
        p_src[0]    = p_pre_reg;
        q_src[0]    = '0;
        big_src[0]  = big_pre_reg;
        side_src[0] = side_pre_reg;
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            r_src[k]    = r_reg[k-1];
            p_src[k]    = p_reg[k-1];
            q_src[k]    = q_reg[k-1];
            big_src[k]  = big_reg[k-1];
            side_src[k] = side_reg[k-1];
        end
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            r_sh[k] = r_src[k] << 1;
            if (r_sh[k] >= p_src[k])
            begin
                r_next[k] = r_sh[k] - p_src[k];
                q_next[k] = {q_src[k][Q_W-2:0], 1'b1};
            end
            else
            begin
                r_next[k] = r_sh[k];
                q_next[k] = {q_src[k][Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else if (ctl.en)
        begin
            pre_valid_reg <= ctl.valid;
            valid_reg     <= {valid_reg[DIV_STEPS-2:0], pre_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            r_pre_reg    <= dividend;
            p_pre_reg    <= divisor;
            big_pre_reg  <= dividend >= divisor;
            side_pre_reg <= side_in;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                r_reg[k]    <= r_next[k];
                p_reg[k]    <= p_src[k];
                q_reg[k]    <= q_next[k];
                big_reg[k]  <= big_src[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    // cosine saturates at one
    assign quotient  = big_reg[DIV_STEPS-1] ? Q_ONE : q_reg[DIV_STEPS-1];
    assign out_valid = valid_reg[DIV_STEPS-1];
    assign side_out  = side_reg[DIV_STEPS-1];

    `ASSERT_ALWAYS(a_quot_range, !out_valid || quotient <= Q_ONE, "cosine above one")

endmodule

### design/v3g_cordic.sv
module v3g_cordic
    import v3g_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  stage_ctl_t                 ctl,
    input  logic signed [CORDIC_W-1:0] x_in,
    input  logic signed [CORDIC_W-1:0] y_in,
    input  logic [SIDE_W-1:0]          side_in,
    output logic                       out_valid,
    output logic signed [CORDIC_W-1:0] angle,
    output logic [SIDE_W-1:0]          side_out
);

    logic [CORDIC_STEPS-1:0]    valid_reg;
    logic signed [CORDIC_W-1:0] x_reg    [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_reg    [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] z_reg    [CORDIC_STEPS];
    logic [SIDE_W-1:0]          side_reg [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] x_src    [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_src    [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] z_src    [CORDIC_STEPS];
    logic [SIDE_W-1:0]          side_src [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] x_next   [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_next   [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] z_next   [CORDIC_STEPS];

    // vectoring mode, drives y toward zero
    always_comb
    begin
        x_src[0]    = x_in;
        y_src[0]    = y_in;
        z_src[0]    = '0;
        side_src[0] = side_in;
        for (int k = 1; k < CORDIC_STEPS; k++)
        begin
            x_src[k]    = x_reg[k-1];
            y_src[k]    = y_reg[k-1];
            z_src[k]    = z_reg[k-1];
            side_src[k] = side_reg[k-1];
        end
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            if (y_src[k] >= 0)
            begin
                x_next[k] = x_src[k] + (y_src[k] >>> k);
                y_next[k] = y_src[k] - (x_src[k] >>> k);
                z_next[k] = z_src[k] + atan_q30(k);
            end
            else
            begin
                x_next[k] = x_src[k] - (y_src[k] >>> k);
                y_next[k] = y_src[k] + (x_src[k] >>> k);
                z_next[k] = z_src[k] - atan_q30(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.en)
        begin
            valid_reg <= {valid_reg[CORDIC_STEPS-2:0], ctl.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                x_reg[k]    <= x_next[k];
                y_reg[k]    <= y_next[k];
                z_reg[k]    <= z_next[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS-1];
    assign angle     = z_reg[CORDIC_STEPS-1];
    assign side_out  = side_reg[CORDIC_STEPS-1];

endmodule

### design/vector3_geometry_unit.sv
// channel  dir  handshake              payload
// in       in   in_valid / in_stall    operation, ax, ay, az, bx, by_comp, bz
// out      out  out_valid / out_stall  result_value
//
// one item per cycle while no stall holds the pipeline; every operation passes through every stage
// the depth comes mostly from the two 33-stage square root chains, the 31-stage divider
// and the 28-stage cordic, each resolving one bit or step per stage
// reset clears only the valid bits
// out_stall with a waiting result freezes every stage; in_stall follows it
`include "assert_macros.svh"

module vector3_geometry_unit
    import v3g_pkg::*;
#(
    parameter int FRAC_BITS = V3G_FRAC_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [OP_W-1:0]         operation,
    input  logic signed [IN_W-1:0]  ax,
    input  logic signed [IN_W-1:0]  ay,
    input  logic signed [IN_W-1:0]  az,
    input  logic signed [IN_W-1:0]  bx,
    input  logic signed [IN_W-1:0]  by_comp,
    input  logic signed [IN_W-1:0]  bz,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] result_value
);

    localparam int VEC_W    = IN_W + 2;
    localparam int MAG_W    = VEC_W - 1;
    localparam int DIF_W    = IN_W + 1;
    localparam int PRD_W    = 2 * IN_W;
    localparam int DSQ_W    = 2 * DIF_W;
    localparam int SUM_W    = PRD_W + 2;
    localparam int NRM_W    = COS_FRAC + 1;
    localparam int NSQ_W    = 2 * NRM_W;
    localparam int SH_W     = 5;
    localparam int NORM_TOP = COS_FRAC - 1;
    localparam int SIDE_W   = $bits(side_t);

    localparam logic signed [VEC_W-1:0]    UNIT_X   = VEC_W'(1) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0]    DOT_HALF = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [CORDIC_W-1:0] ANG_HALF = CORDIC_W'(1) << (COS_FRAC - 1 - FRAC_BITS);
    localparam logic [RAD_W-1:0]           ONE_SQ   = RAD_W'(1) << (2 * COS_FRAC);
    localparam logic signed [OUT_W-1:0]    ANG_MAX  =
        OUT_W'(PI_Q30 >>> (COS_FRAC - FRAC_BITS)) + OUT_W'(1);

    function automatic logic [MAG_W-1:0] mag(input logic signed [VEC_W-1:0] v);
        return (v < 0) ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    function automatic logic [SH_W-1:0] lead_one(input logic [MAG_W-1:0] m);
        logic [SH_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (m[i])
            begin
                idx = SH_W'(i);
            end
        end
        return idx;
    endfunction

    logic pipe_en;

    // stage 1: inputs
    logic                   v1_reg;
    logic [OP_W-1:0]        op1_reg;
    logic signed [IN_W-1:0] a1_reg [3];
    logic signed [IN_W-1:0] b1_reg [3];

    // stage 2: raw products, angle vectors
    logic                    v2_reg;
    logic [OP_W-1:0]         op2_reg;
    logic                    pos2_reg;
    logic signed [PRD_W-1:0] sqa2_reg [3];
    logic signed [DSQ_W-1:0] sqd2_reg [3];
    logic signed [PRD_W-1:0] ab2_reg  [3];
    logic signed [VEC_W-1:0] av2_reg  [3];
    logic signed [VEC_W-1:0] bv2_reg  [3];
    logic [MAG_W-1:0]        ma2_reg;
    logic [MAG_W-1:0]        mb2_reg;

    logic                    a_zero;
    logic                    b_zero;
    logic signed [DIF_W-1:0] dif_w [3];
    logic signed [VEC_W-1:0] av_w  [3];
    logic signed [VEC_W-1:0] bv_w  [3];
    logic [MAG_W-1:0]        ma_w;
    logic [MAG_W-1:0]        mb_w;

    // stage 3: normalized vectors, raw sums
    logic                    v3_reg;
    logic [OP_W-1:0]         op3_reg;
    logic                    pos3_reg;
    logic signed [NRM_W-1:0] an3_reg [3];
    logic signed [NRM_W-1:0] bn3_reg [3];
    logic signed [OUT_W-1:0] dot3_reg;
    logic [RAD_W-1:0]        suma3_reg;
    logic [RAD_W-1:0]        sumd3_reg;

    logic [SH_W-1:0]         sha_w;
    logic [SH_W-1:0]         shb_w;
    logic signed [SUM_W-1:0] dot_sum_w;

    // stage 4: normalized products
    logic                    v4_reg;
    logic [OP_W-1:0]         op4_reg;
    logic                    pos4_reg;
    logic signed [OUT_W-1:0] dot4_reg;
    logic [RAD_W-1:0]        suma4_reg;
    logic [RAD_W-1:0]        sumd4_reg;
    logic signed [NSQ_W-1:0] aa4_reg [3];
    logic signed [NSQ_W-1:0] bb4_reg [3];
    logic signed [NSQ_W-1:0] ab4_reg [3];

    // stage 5: radicands
    logic                    v5_reg;
    logic [RAD_W-1:0]        rad_a5_reg;
    logic [RAD_W-1:0]        rad_b5_reg;
    logic [RAD_W-1:0]        absdot5_reg;
    side_t                   side5_reg;
    logic signed [RAD_W-1:0] dotn_w;
    side_t                   side5_next;
    logic [RAD_W-1:0]        rad_a5_next;

    // square roots of both norms
    stage_ctl_t        ctl_sq;
    logic              va_w;
    logic [SQRT_W-1:0] root_a_w;
    logic [SQRT_W-1:0] root_b_w;
    side_t             side_a_w;
    logic [RAD_W-1:0]  absdot_b_w;

    // product of norms
    logic             vp_reg;
    logic [RAD_W-1:0] p_reg;
    logic [RAD_W-1:0] absdot_p_reg;
    side_t            side_p_reg;
    side_t            side_a_norm;

    // divider
    stage_ctl_t     ctl_div;
    logic           vd_w;
    logic [Q_W-1:0] q_w;
    side_t          side_d_w;

    // cosine squared
    logic             vc_reg;
    logic [RAD_W-1:0] csq_reg;
    logic [Q_W-1:0]   qc_reg;
    side_t            side_c_reg;

    // sine
    stage_ctl_t              ctl_sin;
    logic                    vs_w;
    logic [SQRT_W-1:0]       sin_w;
    logic [SIDE_W+Q_W-1:0]   side_s_w;
    side_t                   side_s_part;
    logic [Q_W-1:0]          cos_s_part;

    // cordic and output
    stage_ctl_t                 ctl_cor;
    logic                       fin_valid;
    logic signed [CORDIC_W-1:0] z_w;
    side_t                      fin_side;
    logic signed [CORDIC_W-1:0] zc_w;
    logic signed [CORDIC_W-1:0] ang_q30_w;
    logic signed [CORDIC_W-1:0] ang_w;
    logic signed [OUT_W-1:0]    result_next;
    logic signed [OUT_W-1:0]    result_reg;
    logic                       out_valid_reg;
    logic                       fin_take;
    logic                       fin_op_known;

    assign pipe_en  = !(out_valid_reg && out_stall);
    assign in_stall = !pipe_en;

    always_comb
    begin
        a_zero = (a1_reg[0] == '0) && (a1_reg[1] == '0) && (a1_reg[2] == '0);
        b_zero = (b1_reg[0] == '0) && (b1_reg[1] == '0) && (b1_reg[2] == '0);
        for (int k = 0; k < 3; k++)
        begin
            dif_w[k] = DIF_W'(a1_reg[k]) - DIF_W'(b1_reg[k]);
            av_w[k]  = VEC_W'(a1_reg[k]);
            bv_w[k]  = VEC_W'(b1_reg[k]);
        end
        // zero vector in an angle, and b of angle_x, becomes the x unit vector
        if (a_zero)
        begin
            av_w[0] = UNIT_X;
        end
        if (op1_reg == OP_ANGLE_X || b_zero)
        begin
            bv_w[0] = UNIT_X;
            bv_w[1] = '0;
            bv_w[2] = '0;
        end
        ma_w = '0;
        mb_w = '0;
        for (int k = 0; k < 3; k++)
        begin
            if (mag(av_w[k]) > ma_w)
            begin
                ma_w = mag(av_w[k]);
            end
            if (mag(bv_w[k]) > mb_w)
            begin
                mb_w = mag(bv_w[k]);
            end
        end
    end

    always_comb
    begin
        sha_w     = SH_W'(NORM_TOP - int'(lead_one(ma2_reg)));
        shb_w     = SH_W'(NORM_TOP - int'(lead_one(mb2_reg)));
        dot_sum_w = SUM_W'(ab2_reg[0]) + SUM_W'(ab2_reg[1]) + SUM_W'(ab2_reg[2]) + DOT_HALF;
    end

    always_comb
    begin
        dotn_w = RAD_W'(ab4_reg[0]) + RAD_W'(ab4_reg[1]) + RAD_W'(ab4_reg[2]);
        case (op4_reg)
            OP_NORM: rad_a5_next = suma4_reg;
            OP_DIST: rad_a5_next = sumd4_reg;
            default: rad_a5_next = RAD_W'(aa4_reg[0]) + RAD_W'(aa4_reg[1])
                                   + RAD_W'(aa4_reg[2]);
        endcase
        side5_next.op      = op4_reg;
        side5_next.dot_res = dot4_reg;
        side5_next.pos     = pos4_reg;
        side5_next.norm    = '0;
        side5_next.dneg    = dotn_w < 0;
    end

    always_comb
    begin
        side_a_norm      = side_a_w;
        side_a_norm.norm = root_a_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            vp_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            vp_reg        <= va_w;
            vc_reg        <= vd_w;
            out_valid_reg <= fin_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            op1_reg   <= operation;
            a1_reg[0] <= ax;
            a1_reg[1] <= ay;
            a1_reg[2] <= az;
            b1_reg[0] <= bx;
            b1_reg[1] <= by_comp;
            b1_reg[2] <= bz;

            op2_reg  <= op1_reg;
            pos2_reg <= a1_reg[0] > 0;
            ma2_reg  <= ma_w;
            mb2_reg  <= mb_w;
            for (int k = 0; k < 3; k++)
            begin
                sqa2_reg[k] <= a1_reg[k] * a1_reg[k];
                sqd2_reg[k] <= dif_w[k] * dif_w[k];
                ab2_reg[k]  <= a1_reg[k] * b1_reg[k];
                av2_reg[k]  <= av_w[k];
                bv2_reg[k]  <= bv_w[k];
            end

            op3_reg   <= op2_reg;
            pos3_reg  <= pos2_reg;
            dot3_reg  <= OUT_W'(dot_sum_w >>> FRAC_BITS);
            suma3_reg <= RAD_W'(sqa2_reg[0]) + RAD_W'(sqa2_reg[1]) + RAD_W'(sqa2_reg[2]);
            sumd3_reg <= RAD_W'(sqd2_reg[0]) + RAD_W'(sqd2_reg[1]) + RAD_W'(sqd2_reg[2]);
            for (int k = 0; k < 3; k++)
            begin
                an3_reg[k] <= NRM_W'(av2_reg[k]) <<< sha_w;
                bn3_reg[k] <= NRM_W'(bv2_reg[k]) <<< shb_w;
            end

            op4_reg   <= op3_reg;
            pos4_reg  <= pos3_reg;
            dot4_reg  <= dot3_reg;
            suma4_reg <= suma3_reg;
            sumd4_reg <= sumd3_reg;
            for (int k = 0; k < 3; k++)
            begin
                aa4_reg[k] <= an3_reg[k] * an3_reg[k];
                bb4_reg[k] <= bn3_reg[k] * bn3_reg[k];
                ab4_reg[k] <= an3_reg[k] * bn3_reg[k];
            end

            rad_a5_reg  <= rad_a5_next;
            rad_b5_reg  <= RAD_W'(bb4_reg[0]) + RAD_W'(bb4_reg[1]) + RAD_W'(bb4_reg[2]);
            absdot5_reg <= (dotn_w < 0) ? RAD_W'(-dotn_w) : RAD_W'(dotn_w);
            side5_reg   <= side5_next;

            p_reg        <= root_a_w * root_b_w;
            absdot_p_reg <= absdot_b_w;
            side_p_reg   <= side_a_norm;

            csq_reg    <= q_w * q_w;
            qc_reg     <= q_w;
            side_c_reg <= side_d_w;

            result_reg <= result_next;
        end
    end

    assign ctl_sq = '{en: pipe_en, valid: v5_reg};

    v3g_sqrt #(
        .SIDE_W   (SIDE_W)
    ) u_sqrt_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_sq),
        .radicand (rad_a5_reg),
        .side_in  (side5_reg),
        .out_valid(va_w),
        .root     (root_a_w),
        .side_out (side_a_w)
    );

    v3g_sqrt #(
        .SIDE_W   (RAD_W)
    ) u_sqrt_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_sq),
        .radicand (rad_b5_reg),
        .side_in  (absdot5_reg),
        .out_valid(),
        .root     (root_b_w),
        .side_out (absdot_b_w)
    );

    assign ctl_div = '{en: pipe_en, valid: vp_reg};

    v3g_div #(
        .SIDE_W   (SIDE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_div),
        .dividend (absdot_p_reg),
        .divisor  (p_reg),
        .side_in  (side_p_reg),
        .out_valid(vd_w),
        .quotient (q_w),
        .side_out (side_d_w)
    );

    assign ctl_sin = '{en: pipe_en, valid: vc_reg};

    v3g_sqrt #(
        .SIDE_W   (SIDE_W + Q_W)
    ) u_sqrt_sin (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_sin),
        .radicand (ONE_SQ - csq_reg),
        .side_in  ({side_c_reg, qc_reg}),
        .out_valid(vs_w),
        .root     (sin_w),
        .side_out (side_s_w)
    );

    assign side_s_part = side_s_w[SIDE_W+Q_W-1:Q_W];
    assign cos_s_part  = side_s_w[Q_W-1:0];
    assign ctl_cor     = '{en: pipe_en, valid: vs_w};

    v3g_cordic #(
        .SIDE_W   (SIDE_W)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_cor),
        .x_in     (CORDIC_W'(cos_s_part)),
        .y_in     (CORDIC_W'(sin_w)),
        .side_in  (side_s_part),
        .out_valid(fin_valid),
        .angle    (z_w),
        .side_out (fin_side)
    );

    always_comb
    begin
        zc_w      = (z_w < 0) ? '0 : z_w;
        ang_q30_w = fin_side.dneg ? (PI_Q30 - zc_w) : zc_w;
        ang_w     = (ang_q30_w + ANG_HALF) >>> (COS_FRAC - FRAC_BITS);
        case (fin_side.op)
            OP_DOT:     result_next = fin_side.dot_res;
            OP_NORM,
            OP_DIST:    result_next = OUT_W'(fin_side.norm);
            OP_ANGLE:   result_next = OUT_W'(ang_w);
            OP_ANGLE_X: result_next = fin_side.pos ? -OUT_W'(ang_w) : OUT_W'(ang_w);
            default:    result_next = '0;
        endcase
    end

    always_comb
    begin
        fin_take     = pipe_en && fin_valid;
        fin_op_known = fin_side.op == OP_DOT || fin_side.op == OP_NORM
                       || fin_side.op == OP_DIST || fin_side.op == OP_ANGLE
                       || fin_side.op == OP_ANGLE_X;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;

    `ASSERT_NEXT(a_unused_zero, fin_take && !fin_op_known, result_value == '0, "unused code")
    `ASSERT_NEXT(a_angle_x_sign, fin_take && fin_side.op == OP_ANGLE_X && fin_side.pos, result_value <= 0, "angle sign")
    `ASSERT_NEXT(a_angle_range, fin_take && fin_side.op == OP_ANGLE, result_value >= 0 && result_value <= ANG_MAX, "angle range")

endmodule
